// ----- src/first_fit_block_allocator_macros.svh -----
// Shared assertion macros for the block allocator checkers.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- src/ffba_pkg.sv -----
`default_nettype none
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ALIGN_BYTES      = 16;
    localparam int ALIGN_MASK       = 15;

    // Opcodes of an input transaction
    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ZERO    = 2'd1;
    localparam logic [1:0] STATUS_NOMEM   = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

    // Configuration register indexes
    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } entry_t;

    // Update broadcast to the cell chain
    typedef enum logic [1:0] {
        CMD_NOP   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SPLIT = 2'd2,
        CMD_MERGE = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
        logic [31:0] nstart;
        logic [31:0] nsize;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ----- src/ffba_cell.sv -----
`default_nettype none
module ffba_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
) (
    input  wire logic              clk,
    input  wire logic [CW-1:0]     count,
    input  wire logic              match_en,
    input  wire logic              free_op,
    input  wire logic [32:0]       need,
    input  wire logic [31:0]       key,
    input  wire logic              prior_in,
    output logic                   prior_out,
    output logic                   first,
    input  wire ffba_pkg::cell_cmd_t cmd,
    input  wire logic [IW-1:0]     cmd_idx,
    input  wire ffba_pkg::entry_t  left,
    input  wire ffba_pkg::entry_t  right,
    output ffba_pkg::entry_t       entry
);

    logic [31:0] start_reg;
    logic [31:0] size_reg;
    logic        free_reg;
    logic        flag_reg;
    logic        live;
    logic        flag_next;
    logic [IW:0] here;
    logic [IW:0] idx_ext;
    logic [IW:0] idx_nxt;

    assign live    = (CW'(IDX) < count);
    assign here    = (IW+1)'(IDX);
    assign idx_ext = {1'b0, cmd_idx};
    assign idx_nxt = idx_ext + (IW+1)'(1);

    // Local match: exact header for a free, any fitting free block for an allocate
    always_comb
    begin
        if (free_op)
            flag_next = live && (start_reg == key);
        else
            flag_next = live && free_reg && ({1'b0, size_reg} >= need);
    end

    always_ff @(posedge clk)
    begin
        if (match_en)
            flag_reg <= flag_next;
    end

    assign prior_out = prior_in | flag_reg;
    assign first     = flag_reg & ~prior_in;

    assign entry.start = start_reg;
    assign entry.size  = size_reg;
    assign entry.free  = free_reg;

    // Apply the broadcast update: write in place or shift with a neighbor
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            ffba_pkg::CMD_WRITE:
            begin
                if (here == idx_ext)
                begin
                    start_reg <= cmd.start;
                    size_reg  <= cmd.size;
                    free_reg  <= cmd.free;
                end
            end
            ffba_pkg::CMD_SPLIT:
            begin
                if (here == idx_ext)
                begin
                    size_reg <= cmd.size;
                    free_reg <= 1'b0;
                end
                else if (here == idx_nxt)
                begin
                    start_reg <= cmd.nstart;
                    size_reg  <= cmd.nsize;
                    free_reg  <= 1'b1;
                end
                else if (here > idx_nxt)
                begin
                    start_reg <= left.start;
                    size_reg  <= left.size;
                    free_reg  <= left.free;
                end
            end
            ffba_pkg::CMD_MERGE:
            begin
                if (here == idx_ext)
                begin
                    size_reg <= cmd.size;
                    free_reg <= 1'b1;
                end
                else if (here > idx_ext)
                begin
                    start_reg <= right.start;
                    size_reg  <= right.size;
                    free_reg  <= right.free;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/first_fit_block_allocator.sv -----
// First-fit heap block allocator. Each cell of a chain of MAX_BLOCKS cells holds one
// block of the address-ordered table; cells compare against the request in parallel
// and shift toward a neighbor to insert or remove an entry. An allocate or a non-null
// free goes through these steps before its result is valid: match in the cells, pick
// the first hit along the chain, compute the update and register the result. The table
// update is broadcast to the cells in the cycle the result is first presented. A
// zero-size allocate or a null free returns its result in the cycle after acceptance.
// A new transaction is taken once the previous result has been consumed. The table
// needs no clearing after reset. heap_base and heap_bytes must be written through the
// cfg port while the allocator is idle; the block itself does not enforce this.
`default_nettype none
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [31:0] request_size,
    input  wire logic [31:0] address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      payload_address,
    output logic [1:0]       status
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR    = 32'(HEADER_BYTES);
    localparam logic [33:0] SPLIT_MIN = 34'(HEADER_BYTES + ffba_pkg::ALIGN_BYTES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_DECIDE = 4'b0100,
        S_APPLY  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] heap_base_reg;
    logic [31:0] heap_bytes_reg;
    logic [31:0] heap_used_reg, heap_used_next;
    logic [CW-1:0] count_reg, count_next;

    logic        op_reg;
    logic [32:0] need_reg;
    logic [31:0] key_reg;

    logic                sel_found_reg;
    logic [IW-1:0]       sel_idx_reg;
    ffba_pkg::entry_t    sel_entry_reg;
    ffba_pkg::entry_t    nxt_entry_reg;

    ffba_pkg::cell_cmd_t cmd_reg, cmd_next;
    logic [IW-1:0]       cmd_idx_reg, cmd_idx_next;

    logic        out_valid_reg;
    logic [31:0] payload_reg, payload_next;
    logic [1:0]  status_reg, status_next;

    logic in_fire;
    logic out_fire;
    logic [32:0] req_round;

    logic [MAX_BLOCKS:0]   prior;
    logic [MAX_BLOCKS-1:0] first;
    ffba_pkg::entry_t      cell_entry [MAX_BLOCKS];

    ffba_pkg::entry_t sel_entry_c;
    ffba_pkg::entry_t nxt_entry_c;
    logic [IW-1:0]    sel_idx_c;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign payload_address = payload_reg;
    assign status          = status_reg;

    assign req_round = ({1'b0, request_size} + 33'(ffba_pkg::ALIGN_MASK))
                       & ~33'(ffba_pkg::ALIGN_MASK);

    // Cell chain
    assign prior[0] = 1'b0;
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        ffba_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .count     (count_reg),
            .match_en  (state_reg == S_MATCH),
            .free_op   (op_reg),
            .need      (need_reg),
            .key       (key_reg),
            .prior_in  (prior[i]),
            .prior_out (prior[i+1]),
            .first     (first[i]),
            .cmd       (cmd_reg),
            .cmd_idx   (cmd_idx_reg),
            .left      (cell_entry[(i > 0) ? i - 1 : 0]),
            .right     (cell_entry[(i < MAX_BLOCKS - 1) ? i + 1 : i]),
            .entry     (cell_entry[i])
        );
    end

    // Gather the first hit and its successor
    always_comb
    begin
        sel_entry_c = '0;
        nxt_entry_c = '0;
        sel_idx_c   = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if (first[i])
            begin
                sel_entry_c.start = sel_entry_c.start | cell_entry[i].start;
                sel_entry_c.size  = sel_entry_c.size  | cell_entry[i].size;
                sel_entry_c.free  = sel_entry_c.free  | cell_entry[i].free;
                sel_idx_c         = sel_idx_c | IW'(i);
                if (i < MAX_BLOCKS - 1)
                begin
                    nxt_entry_c.start = nxt_entry_c.start
                                        | cell_entry[(i < MAX_BLOCKS - 1) ? i + 1 : i].start;
                    nxt_entry_c.size  = nxt_entry_c.size
                                        | cell_entry[(i < MAX_BLOCKS - 1) ? i + 1 : i].size;
                    nxt_entry_c.free  = nxt_entry_c.free
                                        | cell_entry[(i < MAX_BLOCKS - 1) ? i + 1 : i].free;
                end
            end
        end
    end

    // Decide the table update and the result
    logic [33:0] grow_total;
    logic [34:0] grow_top;
    logic        split_ok;
    logic        nxt_live;

    always_comb
    begin
        grow_total = ({1'b0, need_reg} + 34'(HEADER_BYTES + ffba_pkg::ALIGN_MASK))
                     & ~34'(ffba_pkg::ALIGN_MASK);
        grow_top   = {3'b0, heap_used_reg} + {1'b0, grow_total};
        split_ok   = ({2'b0, sel_entry_reg.size} >= ({1'b0, need_reg} + SPLIT_MIN))
                     && (32'(count_reg) < 32'(MAX_BLOCKS));
        nxt_live   = (32'(sel_idx_reg) + 32'd1) < 32'(count_reg);

        cmd_next       = '0;
        cmd_next.op    = ffba_pkg::CMD_NOP;
        cmd_idx_next   = sel_idx_reg;
        count_next     = count_reg;
        heap_used_next = heap_used_reg;
        payload_next   = 32'd0;
        status_next    = ffba_pkg::STATUS_OK;

        if (op_reg == ffba_pkg::OPC_ALLOC)
        begin
            if (sel_found_reg)
            begin
                payload_next = sel_entry_reg.start + HDR;
                if (split_ok)
                begin
                    cmd_next.op     = ffba_pkg::CMD_SPLIT;
                    cmd_next.size   = need_reg[31:0];
                    cmd_next.nstart = sel_entry_reg.start + HDR + need_reg[31:0];
                    cmd_next.nsize  = sel_entry_reg.size - need_reg[31:0] - HDR;
                    count_next      = count_reg + CW'(1);
                end
                else
                begin
                    cmd_next.op    = ffba_pkg::CMD_WRITE;
                    cmd_next.start = sel_entry_reg.start;
                    cmd_next.size  = sel_entry_reg.size;
                    cmd_next.free  = 1'b0;
                end
            end
            else if ((grow_top > {3'b0, heap_bytes_reg})
                     || (32'(count_reg) >= 32'(MAX_BLOCKS)))
            begin
                status_next = ffba_pkg::STATUS_NOMEM;
            end
            else
            begin
                cmd_next.op    = ffba_pkg::CMD_WRITE;
                cmd_idx_next   = count_reg[IW-1:0];
                cmd_next.start = heap_base_reg + heap_used_reg;
                cmd_next.size  = grow_total[31:0] - HDR;
                cmd_next.free  = 1'b0;
                payload_next   = heap_base_reg + heap_used_reg + HDR;
                heap_used_next = grow_top[31:0];
                count_next     = count_reg + CW'(1);
            end
        end
        else
        begin
            if (!sel_found_reg)
                status_next = ffba_pkg::STATUS_UNKNOWN;
            else if (nxt_live && nxt_entry_reg.free)
            begin
                cmd_next.op   = ffba_pkg::CMD_MERGE;
                cmd_next.size = sel_entry_reg.size + HDR + nxt_entry_reg.size;
                count_next    = count_reg - CW'(1);
            end
            else
            begin
                cmd_next.op    = ffba_pkg::CMD_WRITE;
                cmd_next.start = sel_entry_reg.start;
                cmd_next.size  = sel_entry_reg.size;
                cmd_next.free  = 1'b1;
            end
        end
    end

    // Sequence one transaction at a time
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !((opcode == ffba_pkg::OPC_ALLOC) && (request_size == 32'd0))
                            && !((opcode == ffba_pkg::OPC_FREE) && (address == 32'd0)))
                    state_next = S_MATCH;
            end
            S_MATCH:  state_next = S_DECIDE;
            S_DECIDE: state_next = S_APPLY;
            S_APPLY:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_base_reg  <= 32'd0;
            heap_bytes_reg <= 32'd65536;
            heap_used_reg  <= 32'd0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= '0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ffba_pkg::CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                    ffba_pkg::CFG_HEAP_BYTES: heap_bytes_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_fire)
                out_valid_reg <= 1'b0;
            if (in_fire && (state_next == S_IDLE))
                out_valid_reg <= 1'b1;
            if (state_reg == S_APPLY)
            begin
                cmd_reg       <= cmd_next;
                count_reg     <= count_next;
                heap_used_reg <= heap_used_next;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= opcode;
            need_reg    <= req_round;
            key_reg     <= address - HDR;
            payload_reg <= 32'd0;
            status_reg  <= (opcode == ffba_pkg::OPC_ALLOC) ? ffba_pkg::STATUS_ZERO
                                                           : ffba_pkg::STATUS_OK;
        end
        if (state_reg == S_DECIDE)
        begin
            sel_found_reg <= prior[MAX_BLOCKS];
            sel_idx_reg   <= sel_idx_c;
            sel_entry_reg <= sel_entry_c;
            nxt_entry_reg <= nxt_entry_c;
        end
        if (state_reg == S_APPLY)
        begin
            cmd_idx_reg <= cmd_idx_next;
            payload_reg <= payload_next;
            status_reg  <= status_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/ffba_checker.sv -----
`default_nettype none
`include "first_fit_block_allocator_macros.svh"
module ffba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        opcode,
    input wire logic [31:0] request_size,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] payload_address,
    input wire logic [1:0]  status
);

    // Failed or non-allocating results carry a null address
    `FFBA_ASSERT_NOW(a_fail_null, out_valid && (status != ffba_pkg::STATUS_OK), payload_address == 32'd0)

    // One transaction in flight: intake closes after an accept
    `FFBA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // Zero-size allocate answers next cycle
    `FFBA_ASSERT_NEXT(a_zero_fast, in_valid && in_ready && (opcode == ffba_pkg::OPC_ALLOC) && (request_size == 32'd0), out_valid && (status == ffba_pkg::STATUS_ZERO))

    // Hold a stalled result
    `FFBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload_address) && $stable(status))

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .request_size    (request_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .payload_address (payload_address),
    .status          (status)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: tracks the heap table and checks allocator results in order
class heap_scoreboard;
    localparam int TABLE_DEPTH = ffba_pkg::MAX_BLOCKS_DEF;
    localparam int HDR         = ffba_pkg::HEADER_BYTES_DEF;

    bit [31:0] base_addr;
    bit [31:0] limit_bytes;
    bit [31:0] blk_start [TABLE_DEPTH];
    bit [31:0] blk_size [TABLE_DEPTH];
    bit        blk_free [TABLE_DEPTH];
    int        blk_count;
    bit [31:0] top_used;
    bit [33:0] pending_results [$];
    int        error_count;

    function void clear();
        base_addr   = 32'd0;
        limit_bytes = 32'd65536;
        blk_count   = 0;
        top_used    = 32'd0;
        pending_results.delete();
        error_count = 0;
    endfunction

    function void write_reg(logic idx, bit [31:0] value);
        if (idx == ffba_pkg::CFG_HEAP_BASE)
            base_addr = value;
        else
            limit_bytes = value;
    endfunction

    // Shift entries up to open a slot at pos
    function void open_slot(int pos, bit [31:0] s, bit [31:0] z, bit f);
        for (int i = blk_count; i > pos; i--)
        begin
            blk_start[i] = blk_start[i-1];
            blk_size[i]  = blk_size[i-1];
            blk_free[i]  = blk_free[i-1];
        end
        blk_start[pos] = s;
        blk_size[pos]  = z;
        blk_free[pos]  = f;
        blk_count++;
    endfunction

    function void allocate(bit [31:0] req, output bit [31:0] pay, output bit [1:0] st);
        bit [63:0] need;
        bit [63:0] grow;
        pay = 32'd0;
        if (req == 0)
        begin
            st = ffba_pkg::STATUS_ZERO;
            return;
        end
        need = (64'(req) + 15) & ~64'd15;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && 64'(blk_size[i]) >= need)
            begin
                if (64'(blk_size[i]) >= need + HDR + 16 && blk_count < TABLE_DEPTH)
                begin
                    bit [31:0] rest;
                    rest = 32'(64'(blk_size[i]) - need - HDR);
                    blk_size[i] = 32'(need);
                    open_slot(i + 1, 32'(64'(blk_start[i]) + HDR + need), rest, 1'b1);
                end
                blk_free[i] = 1'b0;
                pay = blk_start[i] + HDR;
                st  = ffba_pkg::STATUS_OK;
                return;
            end
        end
        grow = (64'(HDR) + need + 15) & ~64'd15;
        if (64'(top_used) + grow > 64'(limit_bytes) || blk_count >= TABLE_DEPTH)
        begin
            st = ffba_pkg::STATUS_NOMEM;
            return;
        end
        open_slot(blk_count, base_addr + top_used, 32'(grow - HDR), 1'b0);
        pay      = base_addr + top_used + HDR;
        top_used = 32'(64'(top_used) + grow);
        st       = ffba_pkg::STATUS_OK;
    endfunction

    function void release_block(bit [31:0] addr, output bit [1:0] st);
        int hit;
        st = ffba_pkg::STATUS_OK;
        if (addr == 0)
            return;
        hit = -1;
        for (int i = 0; i < blk_count; i++)
        begin
            if (hit < 0 && blk_start[i] + HDR == addr)
                hit = i;
        end
        if (hit < 0)
        begin
            st = ffba_pkg::STATUS_UNKNOWN;
            return;
        end
        blk_free[hit] = 1'b1;
        if (hit + 1 < blk_count && blk_free[hit+1])
        begin
            blk_size[hit] = blk_size[hit] + HDR + blk_size[hit+1];
            // Close the gap left by the merged neighbor
            for (int i = hit + 1; i + 1 < blk_count; i++)
            begin
                blk_start[i] = blk_start[i+1];
                blk_size[i]  = blk_size[i+1];
                blk_free[i]  = blk_free[i+1];
            end
            blk_count--;
        end
    endfunction

    function void note_request(logic opc, bit [31:0] req, bit [31:0] addr);
        bit [31:0] pay;
        bit [1:0]  st;
        pay = 32'd0;
        if (opc == ffba_pkg::OPC_ALLOC)
            allocate(req, pay, st);
        else
            release_block(addr, st);
        pending_results.push_back({pay, st});
    endfunction

    function void check_result(bit [31:0] pay, bit [1:0] st);
        bit [33:0] exp_res;
        if (pending_results.size() == 0)
        begin
            $error("result with none expected: payload_address %h status %0d", pay, st);
            error_count++;
            return;
        end
        exp_res = pending_results.pop_front();
        if (exp_res[33:2] !== pay)
        begin
            $error("payload_address expected %h actual %h", exp_res[33:2], pay);
            error_count++;
        end
        if (exp_res[1:0] !== st)
        begin
            $error("status expected %0d actual %0d", exp_res[1:0], st);
            error_count++;
        end
    endfunction

    // Pick a live payload address, or 0 if none
    function bit [31:0] some_payload();
        if (blk_count == 0)
            return 32'd0;
        return blk_start[$urandom_range(blk_count - 1)] + HDR;
    endfunction
endclass

module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [31:0] request_size;
    logic [31:0] address;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] payload_address;
    logic [1:0]  status;

    heap_scoreboard heap_sb;
    bit             hold_off_req;
    int             idle_cycles;

    first_fit_block_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .request_size(request_size), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .payload_address(payload_address), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Record accepted transactions and check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            heap_sb.note_request(opcode, request_size, address);
        if (rst_n && out_valid && out_ready)
            heap_sb.check_result(payload_address, status);
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin
        int stall_mode;
        int rx_cycles;
        out_ready = 1'b0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (60) @(negedge clk);
                hold_off_req = 1'b0;
            end
            stall_mode = (rx_cycles / 97) % 3;
            rx_cycles++;
            if (stall_mode == 0)
                out_ready = 1'b1;
            else if (stall_mode == 1)
                out_ready = ($urandom_range(3) != 0);
            else
                out_ready = ($urandom_range(1) == 0);
        end
    end

    task automatic send_item(logic opc, bit [31:0] req, bit [31:0] addr);
        in_valid     <= 1'b1;
        opcode       <= opc;
        request_size <= req;
        address      <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        // Random gap between bursts
        if ($urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (heap_sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, bit [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        heap_sb.write_reg(idx, value);
    endtask

    // Mostly plausible sizes, sometimes extreme
    function automatic bit [31:0] pick_size();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return 32'hFFFF_FFF0 + $urandom_range(15);
        if (r < 5)
            return $urandom_range(4096);
        return $urandom_range(300);
    endfunction

    function automatic bit [31:0] pick_free_addr();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return $urandom;
        return heap_sb.some_payload();
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(1) == 0)
                send_item(ffba_pkg::OPC_ALLOC, pick_size(), $urandom);
            else
                send_item(ffba_pkg::OPC_FREE, $urandom, pick_free_addr());
        end
    endtask

    initial
    begin
        heap_sb = new();
        heap_sb.clear();
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = ffba_pkg::CFG_HEAP_BASE;
        cfg_data     = 32'd0;
        in_valid     = 1'b0;
        opcode       = ffba_pkg::OPC_ALLOC;
        request_size = 32'd0;
        address      = 32'd0;
        hold_off_req = 1'b0;
        idle_cycles  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero size, rounding overflow, heap limit, null and unknown free
        send_item(ffba_pkg::OPC_ALLOC, 32'd0, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'hFFFF_FFF1, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'd1, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'd16, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'd200, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'd40, 32'd0);
        send_item(ffba_pkg::OPC_FREE, 32'd0, 32'd0);
        send_item(ffba_pkg::OPC_FREE, 32'd0, 32'hFFFF_FFFF);
        send_item(ffba_pkg::OPC_FREE, 32'd0, 32'd64 + 24);
        send_item(ffba_pkg::OPC_FREE, 32'd0, 32'd24);
        send_item(ffba_pkg::OPC_FREE, 32'd0, 32'd24);
        send_item(ffba_pkg::OPC_ALLOC, 32'd8, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'd100000, 32'd0);
        drain();

        // Extremes of the registers: wrap near the top of the address space
        write_cfg(ffba_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);
        write_cfg(ffba_pkg::CFG_HEAP_BYTES, 32'hFFFF_FFFF);
        send_item(ffba_pkg::OPC_ALLOC, 32'd300, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'hFFFF_0000, 32'd0);
        send_item(ffba_pkg::OPC_FREE, 32'd0, heap_sb.some_payload());
        drain();

        write_cfg(ffba_pkg::CFG_HEAP_BYTES, 32'd0);
        send_item(ffba_pkg::OPC_ALLOC, 32'd1, 32'd0);
        drain();

        // Fill the table: stall the receiver while the sender pushes on
        write_cfg(ffba_pkg::CFG_HEAP_BASE, 32'h1000_0000);
        write_cfg(ffba_pkg::CFG_HEAP_BYTES, 32'd1_000_000);
        hold_off_req = 1'b1;
        for (int n = 0; n < 80; n++)
            send_item(ffba_pkg::OPC_ALLOC, 32'd16, 32'd0);
        drain();
        random_phase(200);
        drain();

        write_cfg(ffba_pkg::CFG_HEAP_BASE, $urandom);
        write_cfg(ffba_pkg::CFG_HEAP_BYTES, 32'd65536);
        random_phase(200);
        drain();

        write_cfg(ffba_pkg::CFG_HEAP_BYTES, 32'd4096);
        random_phase(150);
        drain();

        if (heap_sb.error_count == 0 && heap_sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
